### sv/rcf_pkg.sv
// Shared types, constants and the control store of the rotation consistency filter.
package rcf_pkg;

  // Parameter defaults
  localparam int NUM_BINS_DEF    = 30;
  localparam int MAX_MATCHES_DEF = 4096;

  // Field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 12;
  localparam int ANG_W   = 13;
  localparam int ST_W    = 2;
  localparam int BSEL_W  = 5;   // reported bin index
  localparam int BIN_W   = 6;   // stored bin per match
  localparam int CNT_W   = 13;
  localparam int IDXC_W  = 17;  // index compare width, holds MAX_MATCHES

  localparam logic [BSEL_W-1:0] NONE_BIN  = 5'd30;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 13'h1FFF;
  localparam logic [ANG_W-1:0]  FULL_TURN = 13'd5760;
  localparam logic [ANG_W-1:0]  HALF_STEP = 13'd240;

  // floor(t / 480) for t < 8192 as (t * RECIP_K) >> RECIP_SH
  localparam int                RECIP_W  = 14;
  localparam logic [RECIP_W-1:0] RECIP_K = 14'd8739;
  localparam int                RECIP_SH = 22;
  localparam int                PROD_W   = ANG_W + RECIP_W;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_EVAL   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_REPEAT  = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  // Datapath operation selected by a control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_REC_CHECK,
    ACT_REC_COUNT,
    ACT_QUERY,
    ACT_EVAL_INIT,
    ACT_EVAL_SCAN,
    ACT_EVAL_DONE,
    ACT_SWEEP,
    ACT_CLEAR_REGS
  } act_e;

  // Next-step selection
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_DISPATCH,
    C_BAD,
    C_WALK_END,
    C_SWEEP_END
  } cond_e;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_REC_CHK = 4'd1;
  localparam step_t S_REC_INC = 4'd2;
  localparam step_t S_QRY     = 4'd3;
  localparam step_t S_EV_INIT = 4'd4;
  localparam step_t S_EV_SCAN = 4'd5;
  localparam step_t S_EV_DONE = 4'd6;
  localparam step_t S_CLR     = 4'd7;
  localparam step_t S_CLR_END = 4'd8;
  localparam step_t S_RST     = 4'd9;
  localparam step_t S_EMIT    = 4'd10;

  typedef struct packed {
    logic  in_rdy;
    act_e  act;
    logic  emit;
    cond_e cond;
    step_t target;
  } uword_t;

  // Control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{in_rdy: 1'b0, act: ACT_NONE, emit: 1'b0, cond: C_GOTO, target: S_IDLE};
    case (s)
      S_IDLE:    w = '{1'b1, ACT_NONE,       1'b0, C_DISPATCH,  S_IDLE};
      S_REC_CHK: w = '{1'b0, ACT_REC_CHECK,  1'b0, C_BAD,       S_EMIT};
      S_REC_INC: w = '{1'b0, ACT_REC_COUNT,  1'b1, C_GOTO,      S_IDLE};
      S_QRY:     w = '{1'b0, ACT_QUERY,      1'b1, C_GOTO,      S_IDLE};
      S_EV_INIT: w = '{1'b0, ACT_EVAL_INIT,  1'b0, C_NEXT,      S_IDLE};
      S_EV_SCAN: w = '{1'b0, ACT_EVAL_SCAN,  1'b0, C_WALK_END,  S_EV_DONE};
      S_EV_DONE: w = '{1'b0, ACT_EVAL_DONE,  1'b1, C_GOTO,      S_IDLE};
      S_CLR:     w = '{1'b0, ACT_SWEEP,      1'b0, C_SWEEP_END, S_CLR_END};
      S_CLR_END: w = '{1'b0, ACT_CLEAR_REGS, 1'b1, C_GOTO,      S_IDLE};
      S_RST:     w = '{1'b0, ACT_SWEEP,      1'b0, C_SWEEP_END, S_IDLE};
      S_EMIT:    w = '{1'b0, ACT_NONE,       1'b1, C_GOTO,      S_IDLE};
      default:   w = '{1'b0, ACT_NONE,       1'b0, C_GOTO,      S_IDLE};
    endcase
    return w;
  endfunction

  // Entry step for each opcode
  function automatic step_t op_entry(op_e op);
    step_t s;
    case (op)
      OP_RECORD: s = S_REC_CHK;
      OP_EVAL:   s = S_EV_INIT;
      OP_QUERY:  s = S_QRY;
      OP_CLEAR:  s = S_CLR;
      default:   s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

### sv/rcf_if.sv
// Item and result channel interfaces of the rotation consistency filter.
interface rcf_in_if import rcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] match_index;
  logic [ANG_W-1:0] ref_angle;
  logic [ANG_W-1:0] curr_angle;

  modport source (output valid, opcode, match_index, ref_angle, curr_angle, input ready);
  modport sink   (input valid, opcode, match_index, ref_angle, curr_angle, output ready);
endinterface

interface rcf_out_if import rcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic              keep;
  logic [BSEL_W-1:0] first_bin;
  logic [BSEL_W-1:0] second_bin;
  logic [BSEL_W-1:0] third_bin;
  logic [CNT_W-1:0]  kept_total;

  modport source (output valid, status, keep, first_bin, second_bin, third_bin, kept_total,
                  input ready);
  modport sink   (input valid, status, keep, first_bin, second_bin, third_bin, kept_total,
                  output ready);
endinterface

### sv/rotation_consistency_filter_unit.sv
// Top level: microcoded rotation consistency filter for feature matches.
//
//  channel    dir  handshake      payload
//  item_i     in   valid/ready    opcode, match_index, ref_angle, curr_angle
//  result_o   out  valid/ready    status, keep, first_bin, second_bin, third_bin, kept_total
//  cfg        in   cfg_we_i       cfg_wdata_i -> check_enable
//
// One item at a time. Evaluate makes one count-memory read per bin, and clear
// sweeps the stores with one match-store entry cleared per cycle. After reset the
// same sweep runs before the first item is taken; cfg writes are taken always.
// A result waiting in the output register stalls the step that would emit the
// next one; the item channel is ready only in the idle step.
module rotation_consistency_filter_unit import rcf_pkg::*; #(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int MAX_MATCHES = MAX_MATCHES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  rcf_in_if.sink     item_i,
  rcf_out_if.source  result_o
);

  localparam int AW      = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
  localparam int BW      = $clog2(NUM_BINS);
  localparam int SWEEP_N = (MAX_MATCHES > NUM_BINS) ? MAX_MATCHES : NUM_BINS;
  localparam int SW      = $clog2(SWEEP_N);

  // ---------------------------------------------------------------- sequencer
  step_t  step_q, step_d;
  uword_t uw;
  logic   out_free, go, accept, bad;
  logic   res_valid_q, res_valid_d;

  assign uw       = ucode(step_q);
  assign out_free = !res_valid_q || result_o.ready;
  // an emitting step waits for the output register; nothing else moves meanwhile
  assign go       = !(uw.emit && !out_free);
  assign accept   = uw.in_rdy && item_i.valid;
  assign item_i.ready = uw.in_rdy;

  // ---------------------------------------------------------------- state
  logic                           enable_q;
  op_e                            op_q, op_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [ANG_W-1:0]               diff_q, diff_d;
  logic [BIN_W-1:0]               bin_q, bin_d;
  status_e                        st_q, st_d;
  logic [SW-1:0]                  swp_q, swp_d;
  logic [BW-1:0]                  walk_q, walk_d;
  logic [2:0][CNT_W-1:0]          top_q, top_d;     // running top-3 counts
  logic [2:0][BSEL_W-1:0]         topi_q, topi_d;   // and their bins
  logic [2:0][BSEL_W-1:0]         chosen_q, chosen_d;
  logic [2:0][CNT_W-1:0]          mir_q, mir_d;     // live counts of the chosen bins
  logic [CNT_W-1:0]               total_q, total_d; // all recorded, saturated
  logic                           keep_d;

  // result register
  status_e           res_st_q;
  logic              res_keep_q;
  logic [BSEL_W-1:0] res_b0_q, res_b1_q, res_b2_q;
  logic [CNT_W-1:0]  res_kept_q;

  // ---------------------------------------------------------------- memories
  logic [BIN_W:0]    mstore [MAX_MATCHES];   // {recorded, bin}
  logic [CNT_W-1:0]  cstore [NUM_BINS];
  logic              m_we, m_re, c_we, c_re;
  logic [AW-1:0]     m_wa, m_ra;
  logic [BIN_W:0]    m_wd, mrd_q;
  logic [BW-1:0]     c_wa, c_ra;
  logic [CNT_W-1:0]  c_wd, crd_q;

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      mstore[m_wa] <= m_wd;
    end
    if (m_re) begin
      mrd_q <= mstore[m_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cstore[c_wa] <= c_wd;
    end
    if (c_re) begin
      crd_q <= cstore[c_ra];
    end
  end

  // ---------------------------------------------------------------- angle diff
  // both angles folded into one turn, difference wrapped into 0..5759
  logic [ANG_W-1:0] ra_red, ca_red, diff_w;
  logic [ANG_W:0]   diff_raw;

  always_comb begin
    ra_red   = (item_i.ref_angle  >= FULL_TURN) ? item_i.ref_angle  - FULL_TURN
                                                : item_i.ref_angle;
    ca_red   = (item_i.curr_angle >= FULL_TURN) ? item_i.curr_angle - FULL_TURN
                                                : item_i.curr_angle;
    diff_raw = {1'b0, ra_red} - {1'b0, ca_red};
    diff_w   = diff_raw[ANG_W] ? diff_raw[ANG_W-1:0] + FULL_TURN : diff_raw[ANG_W-1:0];
  end

  // bin = floor((d + 240) / 480) through a reciprocal multiply
  logic [ANG_W-1:0]  t_sum;
  logic [PROD_W-1:0] prod;
  logic [BIN_W-1:0]  quo, bin_calc;

  always_comb begin
    t_sum    = diff_q + HALF_STEP;
    prod     = PROD_W'(t_sum) * PROD_W'(RECIP_K);
    quo      = BIN_W'(prod[RECIP_SH +: BSEL_W]);
    bin_calc = ({1'b0, quo} >= (BIN_W+1)'(NUM_BINS)) ? '0 : quo;
  end

  // ---------------------------------------------------------------- index checks
  logic [IDXC_W-1:0] idx_ext, in_idx_ext;
  logic              idx_oor;

  assign idx_ext    = IDXC_W'(idx_q);
  assign in_idx_ext = IDXC_W'(item_i.match_index);
  assign idx_oor    = idx_ext >= IDXC_W'(MAX_MATCHES);

  logic walk_end, sweep_end;
  assign walk_end  = walk_q == BW'(NUM_BINS - 1);
  assign sweep_end = swp_q == SW'(SWEEP_N - 1);

  // ---------------------------------------------------------------- datapath
  logic [CNT_W-1:0]    cnt_new, s;
  logic [CNT_W+3:0]    m2x10, m3x10;
  logic                q_hit;

  always_comb begin
    op_d     = op_q;
    idx_d    = idx_q;
    diff_d   = diff_q;
    bin_d    = bin_q;
    st_d     = st_q;
    swp_d    = swp_q;
    walk_d   = walk_q;
    top_d    = top_q;
    topi_d   = topi_q;
    chosen_d = chosen_q;
    mir_d    = mir_q;
    total_d  = total_q;
    keep_d   = 1'b0;
    bad      = 1'b0;
    m_we     = 1'b0;
    m_wa     = '0;
    m_wd     = '0;
    m_re     = 1'b0;
    m_ra     = '0;
    c_we     = 1'b0;
    c_wa     = '0;
    c_wd     = '0;
    c_re     = 1'b0;
    c_ra     = '0;
    cnt_new  = (crd_q == COUNT_MAX) ? crd_q : crd_q + 1'b1;
    s        = crd_q;
    m2x10    = ({4'b0, top_q[1]} << 3) + ({4'b0, top_q[1]} << 1);
    m3x10    = ({4'b0, top_q[2]} << 3) + ({4'b0, top_q[2]} << 1);
    q_hit    = (mrd_q[BIN_W-1:0] == {1'b0, chosen_q[0]}) ||
               (mrd_q[BIN_W-1:0] == {1'b0, chosen_q[1]}) ||
               (mrd_q[BIN_W-1:0] == {1'b0, chosen_q[2]});

    if (accept) begin
      op_d   = op_e'(item_i.opcode);
      idx_d  = item_i.match_index;
      diff_d = diff_w;
      st_d   = ST_OK;
      m_re   = 1'b1;
      m_ra   = in_idx_ext[AW-1:0];
    end

    if (go) begin
      case (uw.act)
        ACT_REC_CHECK: begin
          bin_d = bin_calc;
          c_re  = 1'b1;
          c_ra  = bin_calc[BW-1:0];
          if (idx_oor) begin
            st_d = ST_UNKNOWN;
            bad  = 1'b1;
          end else if (mrd_q[BIN_W]) begin
            st_d = ST_REPEAT;
            bad  = 1'b1;
          end else begin
            m_we = 1'b1;
            m_wa = idx_ext[AW-1:0];
            m_wd = {1'b1, bin_calc};
          end
        end
        ACT_REC_COUNT: begin
          c_we = 1'b1;
          c_wa = bin_q[BW-1:0];
          c_wd = cnt_new;
          if (crd_q != COUNT_MAX && total_q != COUNT_MAX) begin
            total_d = total_q + 1'b1;
          end
          for (int k = 0; k < 3; k++) begin
            if ({1'b0, chosen_q[k]} == bin_q) begin
              mir_d[k] = cnt_new;
            end
          end
        end
        ACT_QUERY: begin
          if (idx_oor || !mrd_q[BIN_W]) begin
            st_d = ST_UNKNOWN;
          end else begin
            keep_d = !enable_q || q_hit;
          end
        end
        ACT_EVAL_INIT: begin
          top_d  = '0;
          topi_d = {NONE_BIN, NONE_BIN, NONE_BIN};
          walk_d = '0;
          c_re   = 1'b1;
          c_ra   = '0;
        end
        ACT_EVAL_SCAN: begin
          // earlier bins win ties: strict compares only
          if (s > top_q[0]) begin
            top_d  = {top_q[1], top_q[0], s};
            topi_d = {topi_q[1], topi_q[0], BSEL_W'(walk_q)};
          end else if (s > top_q[1]) begin
            top_d[2]  = top_q[1];
            top_d[1]  = s;
            topi_d[2] = topi_q[1];
            topi_d[1] = BSEL_W'(walk_q);
          end else if (s > top_q[2]) begin
            top_d[2]  = s;
            topi_d[2] = BSEL_W'(walk_q);
          end
          walk_d = walk_q + 1'b1;
          // no read past the last bin
          c_re   = !walk_end;
          c_ra   = walk_q + 1'b1;
        end
        ACT_EVAL_DONE: begin
          chosen_d = topi_q;
          mir_d    = top_q;
          if (m2x10 < {4'b0, top_q[0]}) begin
            chosen_d[1] = NONE_BIN;
            chosen_d[2] = NONE_BIN;
            mir_d[1]    = '0;
            mir_d[2]    = '0;
          end else if (m3x10 < {4'b0, top_q[0]}) begin
            chosen_d[2] = NONE_BIN;
            mir_d[2]    = '0;
          end
        end
        ACT_SWEEP: begin
          if ({1'b0, swp_q} < (SW+1)'(MAX_MATCHES)) begin
            m_we = 1'b1;
            m_wa = swp_q[AW-1:0];
            m_wd = '0;
          end
          if ({1'b0, swp_q} < (SW+1)'(NUM_BINS)) begin
            c_we = 1'b1;
            c_wa = swp_q[BW-1:0];
            c_wd = '0;
          end
          swp_d = sweep_end ? '0 : swp_q + 1'b1;
        end
        ACT_CLEAR_REGS: begin
          chosen_d = {NONE_BIN, NONE_BIN, NONE_BIN};
          mir_d    = '0;
          total_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // next step
  always_comb begin
    case (uw.cond)
      C_NEXT:      step_d = step_q + 1'b1;
      C_GOTO:      step_d = uw.target;
      C_DISPATCH:  step_d = accept ? op_entry(op_e'(item_i.opcode)) : step_q;
      C_BAD:       step_d = bad ? uw.target : step_q + 1'b1;
      C_WALK_END:  step_d = walk_end ? uw.target : step_q;
      C_SWEEP_END: step_d = sweep_end ? uw.target : step_q;
      default:     step_d = S_IDLE;
    endcase
    if (!go) begin
      step_d = step_q;
    end
  end

  // kept total from the values this step leaves behind
  logic [CNT_W+1:0] kept_sum;
  logic [CNT_W-1:0] kept_calc;

  always_comb begin
    kept_sum = '0;
    for (int k = 0; k < 3; k++) begin
      if (chosen_d[k] != NONE_BIN) begin
        kept_sum = kept_sum + (CNT_W+2)'(mir_d[k]);
      end
    end
    if (!enable_q) begin
      kept_calc = total_d;
    end else if (kept_sum > (CNT_W+2)'(COUNT_MAX)) begin
      kept_calc = COUNT_MAX;
    end else begin
      kept_calc = kept_sum[CNT_W-1:0];
    end
  end

  logic emit_now;
  assign emit_now = go && uw.emit;

  always_comb begin
    res_valid_d = res_valid_q;
    if (emit_now) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_RST;
      enable_q    <= 1'b1;
      swp_q       <= '0;
      walk_q      <= '0;
      st_q        <= ST_OK;
      op_q        <= OP_RECORD;
      chosen_q    <= {NONE_BIN, NONE_BIN, NONE_BIN};
      mir_q       <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      swp_q       <= swp_d;
      walk_q      <= walk_d;
      st_q        <= st_d;
      op_q        <= op_d;
      chosen_q    <= chosen_d;
      mir_q       <= mir_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    diff_q <= diff_d;
    bin_q  <= bin_d;
    top_q  <= top_d;
    topi_q <= topi_d;
    if (emit_now) begin
      res_st_q   <= st_d;
      res_keep_q <= keep_d;
      res_b0_q   <= chosen_d[0];
      res_b1_q   <= chosen_d[1];
      res_b2_q   <= chosen_d[2];
      res_kept_q <= kept_calc;
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.status     = res_st_q;
  assign result_o.keep       = res_keep_q;
  assign result_o.first_bin  = res_b0_q;
  assign result_o.second_bin = res_b1_q;
  assign result_o.third_bin  = res_b2_q;
  assign result_o.kept_total = res_kept_q;

endmodule

### tb/rotation_consistency_filter_unit_checker.sv
// Scoreboard for the rotation consistency filter: predicts every result and checks it.
module rotation_consistency_filter_unit_checker import rcf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  rcf_in_if    item_i,
  rcf_out_if   result_i,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS      = NUM_BINS_DEF;
  localparam int NMATCH     = MAX_MATCHES_DEF;
  localparam int BIN_STEP   = 480;

  typedef struct packed {
    status_e             status;
    logic                keep;
    logic [BSEL_W-1:0]   first_bin;
    logic [BSEL_W-1:0]   second_bin;
    logic [BSEL_W-1:0]   third_bin;
    logic [CNT_W-1:0]    kept_total;
  } filter_result_t;

  logic              check_on;
  logic [CNT_W-1:0]  bin_tally [NBINS];
  logic [BIN_W-1:0]  match_slot [NMATCH];
  bit                match_seen [NMATCH];
  logic [BSEL_W-1:0] top_bins [3];
  filter_result_t    expected_results [$];
  int                errors;

  function automatic void wipe_store();
    for (int i = 0; i < NBINS; i++) bin_tally[i] = '0;
    for (int i = 0; i < NMATCH; i++) begin
      match_slot[i] = '0;
      match_seen[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) top_bins[i] = NONE_BIN;
  endfunction

  // wrapped difference rounded to the nearest 30 degree step
  function automatic int angle_to_bin(logic [ANG_W-1:0] a, logic [ANG_W-1:0] b);
    int ra, rb, d, bin;
    ra = int'(a);
    rb = int'(b);
    if (ra >= int'(FULL_TURN)) ra -= int'(FULL_TURN);
    if (rb >= int'(FULL_TURN)) rb -= int'(FULL_TURN);
    d = ra - rb;
    if (d < 0) d += int'(FULL_TURN);
    bin = (d + int'(HALF_STEP)) / BIN_STEP;
    if (bin >= NBINS) bin = 0;
    return bin;
  endfunction

  function automatic bit bin_kept(int b);
    if (!check_on) return 1'b1;
    return b == int'(top_bins[0]) || b == int'(top_bins[1]) || b == int'(top_bins[2]);
  endfunction

  function automatic logic [CNT_W-1:0] kept_count();
    int s;
    s = 0;
    for (int i = 0; i < NBINS; i++)
      if (bin_kept(i)) s += int'(bin_tally[i]);
    if (s > int'(COUNT_MAX)) s = int'(COUNT_MAX);
    return s[CNT_W-1:0];
  endfunction

  // three fullest bins, earlier wins ties, runners-up dropped below a tenth of the top
  function automatic void rank_bins();
    int m1, m2, m3, s;
    logic [BSEL_W-1:0] i1, i2, i3;
    m1 = 0; m2 = 0; m3 = 0;
    i1 = NONE_BIN; i2 = NONE_BIN; i3 = NONE_BIN;
    for (int i = 0; i < NBINS; i++) begin
      s = int'(bin_tally[i]);
      if (s > m1) begin
        m3 = m2; m2 = m1; m1 = s;
        i3 = i2; i2 = i1; i1 = i[BSEL_W-1:0];
      end else if (s > m2) begin
        m3 = m2; m2 = s;
        i3 = i2; i2 = i[BSEL_W-1:0];
      end else if (s > m3) begin
        m3 = s;
        i3 = i[BSEL_W-1:0];
      end
    end
    if (10 * m2 < m1) begin
      i2 = NONE_BIN;
      i3 = NONE_BIN;
    end else if (10 * m3 < m1) begin
      i3 = NONE_BIN;
    end
    top_bins[0] = i1;
    top_bins[1] = i2;
    top_bins[2] = i3;
  endfunction

  function automatic filter_result_t predict_item(op_e op, logic [IDX_W-1:0] idx,
                                                  logic [ANG_W-1:0] ra, logic [ANG_W-1:0] ca);
    filter_result_t r;
    int b;
    r.status = ST_OK;
    r.keep   = 1'b0;
    case (op)
      OP_RECORD: begin
        if (match_seen[idx]) begin
          r.status = ST_REPEAT;
        end else begin
          b = angle_to_bin(ra, ca);
          match_seen[idx] = 1'b1;
          match_slot[idx] = b[BIN_W-1:0];
          if (bin_tally[b] < COUNT_MAX) bin_tally[b] = bin_tally[b] + 1'b1;
        end
      end
      OP_EVAL: rank_bins();
      OP_QUERY: begin
        if (!match_seen[idx]) r.status = ST_UNKNOWN;
        else r.keep = bin_kept(int'(match_slot[idx]));
      end
      OP_CLEAR: wipe_store();
      default: ;
    endcase
    r.first_bin  = top_bins[0];
    r.second_bin = top_bins[1];
    r.third_bin  = top_bins[2];
    r.kept_total = kept_count();
    return r;
  endfunction

  function automatic void compare_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  initial begin
    check_on  = 1'b1;
    errors    = 0;
    errors_o  = 0;
    pending_o = 0;
    wipe_store();
  end

  always @(posedge clk_i) begin : monitor
    filter_result_t want, got;
    if (rst_ni) begin
      if (cfg_we_i) check_on = cfg_wdata_i;
      if (result_i.valid && result_i.ready) begin
        got.status     = status_e'(result_i.status);
        got.keep       = result_i.keep;
        got.first_bin  = result_i.first_bin;
        got.second_bin = result_i.second_bin;
        got.third_bin  = result_i.third_bin;
        got.kept_total = result_i.kept_total;
        if (expected_results.size() == 0) begin
          errors++;
          $error("result item with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          compare_field("status", CNT_W'(want.status), CNT_W'(got.status));
          compare_field("keep", CNT_W'(want.keep), CNT_W'(got.keep));
          compare_field("first_bin", CNT_W'(want.first_bin), CNT_W'(got.first_bin));
          compare_field("second_bin", CNT_W'(want.second_bin), CNT_W'(got.second_bin));
          compare_field("third_bin", CNT_W'(want.third_bin), CNT_W'(got.third_bin));
          compare_field("kept_total", want.kept_total, got.kept_total);
        end
      end
      if (item_i.valid && item_i.ready)
        expected_results = {expected_results,
                            predict_item(op_e'(item_i.opcode), item_i.match_index,
                                         item_i.ref_angle, item_i.curr_angle)};
      errors_o  = errors;
      pending_o = expected_results.size();
    end
  end

endmodule

### tb/rotation_consistency_filter_unit_tb.sv
// Testbench top for the rotation consistency filter: stimulus, back-pressure and verdict.
module rotation_consistency_filter_unit_tb import rcf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_ITEMS     = 1400;
  localparam int IDLE_PCT      = 37;
  localparam int SETTLE_CYCLES = 4;       // margin after the last result before a cfg write
  localparam int DRAIN_CYCLES  = 64;
  localparam int STALL_AT      = 300;     // result count that triggers the long hold-off
  localparam int STALL_CYCLES  = 400;
  // Slowest plausible run: ~80 rounds each paying a full clear sweep, plus ~1.4k items
  // at evaluate length with worst gaps on both sides, the reset sweep and the hold-off.
  // The limit is set to cover that run.
  localparam int CYCLE_LIMIT   = 2_000_000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;
  int   check_errors;
  int   results_pending;
  int   results_seen = 0;
  int   items_sent   = 0;
  bit   steady       = 1'b0;   // both sides run without gaps while set

  // indexes recorded since the last clear, as the block should see them
  bit               taken [int];
  logic [IDX_W-1:0] used  [$];

  rcf_in_if  item_if ();
  rcf_out_if result_if ();

  rotation_consistency_filter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  rotation_consistency_filter_unit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_i    (result_if),
    .errors_o    (check_errors),
    .pending_o   (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: whatever hangs, the run ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[rotation_consistency_filter_unit] ERROR");
    $finish;
  end

  always @(posedge clk_i)
    if (result_if.valid && result_if.ready) results_seen <= results_seen + 1;

  // Result side: random ready, gap-free while steady, and one long hold-off so the
  // output register fills, the block stalls and the sender is left waiting on ready.
  initial begin : result_sink
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= STALL_AT) begin
        held      = 1'b1;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        result_if.ready = 1'b0;
        hold_left--;
      end else begin
        result_if.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offers one item after random gaps and returns at the falling edge after it is
  // taken, valid still high; the caller either offers the next item or drops valid.
  task automatic send_item(op_e op, logic [IDX_W-1:0] idx,
                           logic [ANG_W-1:0] ra, logic [ANG_W-1:0] ca);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      item_if.valid = 1'b0;
      @(negedge clk_i);
    end
    item_if.valid       = 1'b1;
    item_if.opcode      = op;
    item_if.match_index = idx;
    item_if.ref_angle   = ra;
    item_if.curr_angle  = ca;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    // mirror the index store so later items can aim at recorded or fresh matches
    if (op == OP_RECORD && !taken.exists(idx)) begin
      taken[idx] = 1'b1;
      used = {used, idx};
    end else if (op == OP_CLEAR) begin
      taken.delete();
      used.delete();
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic quiesce();
    item_if.valid = 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_check(bit on);
    quiesce();
    cfg_we    = 1'b1;
    cfg_wdata = on;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // Angles whose wrapped difference lands in the wanted bin; now and then an
  // angle is given in its alias above a full turn.
  task automatic record_in_bin(logic [IDX_W-1:0] idx, int bin);
    int d, c, r;
    if (bin == 0) d = $urandom_range(0, 239);
    else if (bin == 12) d = 5520 + $urandom_range(0, 239);
    else d = bin * 480 - 240 + $urandom_range(0, 479);
    c = $urandom_range(0, 5759);
    r = (c + d) % 5760;
    if ($urandom_range(0, 7) == 0 && c < 8192 - 5760) c += 5760;
    if ($urandom_range(0, 7) == 0 && r < 8192 - 5760) r += 5760;
    send_item(OP_RECORD, idx, r[ANG_W-1:0], c[ANG_W-1:0]);
  endtask

  function automatic logic [IDX_W-1:0] fresh_index();
    logic [IDX_W-1:0] idx;
    do idx = IDX_W'($urandom_range(0, 4095)); while (taken.exists(idx));
    return idx;
  endfunction

  // Mostly recorded matches, sometimes an arbitrary index.
  task automatic query_some(int n);
    logic [IDX_W-1:0] idx;
    repeat (n) begin
      if (used.size() > 0 && $urandom_range(0, 99) < 80)
        idx = used[$urandom_range(0, used.size() - 1)];
      else
        idx = IDX_W'($urandom_range(0, 4095));
      send_item(OP_QUERY, idx, ANG_W'($urandom_range(0, 8191)),
                ANG_W'($urandom_range(0, 8191)));
    end
  endtask

  task automatic directed_items();
    send_item(OP_EVAL, 12'd0, 13'd0, 13'd0);             // empty histogram: no bin chosen
    send_item(OP_QUERY, 12'd0, 13'd0, 13'd0);            // index never recorded
    send_item(OP_RECORD, 12'd0, 13'd0, 13'd0);           // zero difference
    send_item(OP_RECORD, 12'd4095, 13'd5759, 13'd0);     // just short of a full turn
    send_item(OP_RECORD, 12'd0, 13'd480, 13'd0);         // repeated index, no change
    send_item(OP_RECORD, 12'd1, 13'd8191, 13'd5760);     // both angles above a turn
    send_item(OP_RECORD, 12'd2, 13'd0, 13'd5759);        // negative difference wraps
    send_item(OP_RECORD, 12'd3, 13'd240, 13'd0);         // half step rounds up
    send_item(OP_RECORD, 12'd4, 13'd239, 13'd0);         // just below half step
    send_item(OP_RECORD, 12'd2730, 13'd5461, 13'd2730);
    send_item(OP_EVAL, 12'd0, 13'd0, 13'd0);             // ties among single-count bins
    send_item(OP_QUERY, 12'd4095, 13'd0, 13'd0);
    send_item(OP_QUERY, 12'd3, 13'd0, 13'd0);
    send_item(OP_QUERY, 12'd100, 13'd0, 13'd0);
    write_check(1'b0);                                   // filter off: everything kept
    send_item(OP_QUERY, 12'd4095, 13'd0, 13'd0);
    send_item(OP_EVAL, 12'd0, 13'd0, 13'd0);             // still ranks while off
    send_item(OP_CLEAR, 12'd0, 13'd0, 13'd0);
    send_item(OP_QUERY, 12'd0, 13'd0, 13'd0);
    send_item(OP_EVAL, 12'd0, 13'd0, 13'd0);
    write_check(1'b1);
  endtask

  // One histogram: a planned mix of bins recorded in random order, with repeats and
  // stray items, then an evaluate and queries, sometimes a late top-up and re-rank.
  task automatic run_round();
    int plan [$];
    int mode, lead, c2, c3, hot, k, c, j, tmp;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      repeat ($urandom_range(1, 40)) plan = {plan, int'($urandom_range(0, 12))};
    end else if (mode < 7) begin
      // one bin far ahead; runners-up near a tenth of it either side
      lead = $urandom_range(5, 40);
      c2   = $urandom_range(0, lead / 10 + 2);
      c3   = $urandom_range(0, c2 + 1);
      hot  = $urandom_range(0, 12);
      repeat (lead) plan = {plan, hot};
      hot  = $urandom_range(0, 12);
      repeat (c2) plan = {plan, hot};
      hot  = $urandom_range(0, 12);
      repeat (c3) plan = {plan, hot};
      repeat ($urandom_range(0, 2)) plan = {plan, int'($urandom_range(0, 12))};
    end else if (mode < 9) begin
      // equal counts, so the ranking falls back on bin order
      c = $urandom_range(1, 8);
      k = $urandom_range(2, 4);
      repeat (k) begin
        hot = $urandom_range(0, 12);
        repeat (c) plan = {plan, hot};
      end
    end else begin
      repeat ($urandom_range(150, 350)) plan = {plan, int'($urandom_range(0, 12))};
    end

    for (int i = plan.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = plan[i];
      plan[i] = plan[j];
      plan[j] = tmp;
    end

    foreach (plan[i]) begin
      if (used.size() > 0 && $urandom_range(0, 99) < 8)
        record_in_bin(used[$urandom_range(0, used.size() - 1)], $urandom_range(0, 12));
      if ($urandom_range(0, 99) < 5)
        send_item(op_e'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 4095)),
                  ANG_W'($urandom_range(0, 8191)), ANG_W'($urandom_range(0, 8191)));
      record_in_bin(fresh_index(), plan[i]);
    end

    send_item(OP_EVAL, IDX_W'($urandom_range(0, 4095)), ANG_W'($urandom_range(0, 8191)),
              ANG_W'($urandom_range(0, 8191)));
    query_some($urandom_range(2, 12));

    if ($urandom_range(0, 99) < 40) begin
      repeat ($urandom_range(1, 5)) record_in_bin(fresh_index(), $urandom_range(0, 12));
      query_some($urandom_range(1, 4));
      if ($urandom_range(0, 1) == 1) begin
        send_item(OP_EVAL, 12'd0, 13'd0, 13'd0);
        query_some($urandom_range(1, 6));
      end
    end
  endtask

  initial begin : stimulus
    int round_no;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    item_if.valid       = 1'b0;
    item_if.opcode      = OP_RECORD;
    item_if.match_index = '0;
    item_if.ref_angle   = '0;
    item_if.curr_angle  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // the block sweeps its store after reset; the first item simply waits on ready
    directed_items();

    round_no = 0;
    while (items_sent < RUN_ITEMS) begin
      steady = (round_no >= 4 && round_no < 7);
      if ($urandom_range(0, 3) == 0) write_check(1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 4) == 0) quiesce();
      if ($urandom_range(0, 6) != 0)
        send_item(OP_CLEAR, IDX_W'($urandom_range(0, 4095)), ANG_W'($urandom_range(0, 8191)),
                  ANG_W'($urandom_range(0, 8191)));
      run_round();
      round_no++;
    end
    steady = 1'b0;

    // drain, then give a late or stray result time to show up
    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (check_errors == 0 && results_pending == 0)
      $display("[rotation_consistency_filter_unit] OK");
    else
      $display("[rotation_consistency_filter_unit] ERROR");
    $finish;
  end

endmodule
